// File: rtl/tcs_pkg.sv
// tcs_pkg: shared types and constants for the throttle curve shaper.
// No dependencies; used by throttle_curve_shaper, tcs_exp_unit, tcs_pipe and the testbench files.
`default_nettype none

package tcs_pkg;

  // Fixed-point ones
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [14:0] ONE_Q14 = 15'd16384;
  localparam logic signed [15:0] CURVE_LIMIT = 16'sd20480;

  // Curve mode codes
  localparam logic [1:0] MODE_POWER = 2'd0;
  localparam logic [1:0] MODE_EXPO  = 2'd1;
  localparam logic [1:0] MODE_POLY  = 2'd2;
  localparam logic [1:0] MODE_LIN   = 2'd3;

  // Register indexes (paddr[2])
  localparam logic REG_SHAPE = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  // Static curve settings handed to the datapath
  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] a;      // |curve|, clamped, Q4.12
    logic        cpos;
    logic        cneg;
    logic [30:0] b;      // e^(-a), Q30
    logic        bge;    // b >= 1.0
  } curve_cfg_t;

  // One item as it travels down the datapath
  typedef struct packed {
    logic        neg;
    logic [1:0]  mode;
    logic        cpos;
    logic        cneg;
    logic [14:0] x;
    logic [14:0] w;
    logic [2:0]  whole;
    logic [13:0] nfrac;
    logic [30:0] base;
    logic [30:0] acc;
    logic [60:0] srem;
    logic [30:0] sres;
    logic [30:0] dnum;
    logic [33:0] dden;
    logic [60:0] drem;
    logic [30:0] quot;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/tcs_if.sv
// tcs_if: valid/ready channel interfaces for command input and shaped output.
// Depends on nothing.
`default_nettype none

interface tcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] command_in;
  modport source (output valid, output command_in, input ready);
  modport sink   (input valid, input command_in, output ready);
endinterface

interface tcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] command_out;
  modport source (output valid, output command_out, input ready);
  modport sink   (input valid, input command_out, output ready);
endinterface

`default_nettype wire

// File: rtl/throttle_curve_shaper.sv
// throttle_curve_shaper: top level with config registers, datapath and output skid buffer.
// Depends on tcs_pkg, tcs_if, tcs_exp_unit and tcs_pipe.
//
//   channel   | direction | transfer / access
//   in_chan   | sink      | command_in, on valid & ready
//   out_chan  | source    | command_out, on valid & ready
//   APB port  | slave     | curve_shape @0x0, curve_mode @0x4, write on psel&penable&pwrite
//
// One command per cycle while in_chan.ready is high; the pipe holds entry, prep, six whole-power
// multiplies, fourteen 32-stage square-root/multiply blocks, a 31-stage divider, output and skid.
// A write to curve_shape starts the e^(-a) sequencer, whose shared divider takes one bit
// per cycle: in_chan.ready stays low after that write while the sequencer is busy.
// Reset clears valid bits and registers (curve_shape 0, linear mode); no memory sweep.
// A stalled output holds the whole pipe once both skid entries are full.
`default_nettype none

module throttle_curve_shaper (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcs_in_if.sink     in_chan,
  tcs_out_if.source  out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic signed [15:0]  shape_r;
  logic [1:0]          mode_r;
  logic                cfg_wr;
  logic signed [15:0]  c_cl;
  tcs_pkg::curve_cfg_t cfg;
  logic                exp_busy;
  logic [30:0]         exp_b;
  logic                en, in_fire;
  logic                pipe_vld;
  logic [15:0]         pipe_cmd;
  logic [15:0]         fifo_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;
  logic                push, pop;

  // Clamped magnitude of a written curve value
  function automatic logic [14:0] exp_a(input logic [15:0] v);
    logic signed [15:0] s;
    s = v;
    if (s > tcs_pkg::CURVE_LIMIT) s = tcs_pkg::CURVE_LIMIT;
    else if (s < -tcs_pkg::CURVE_LIMIT) s = -tcs_pkg::CURVE_LIMIT;
    return s[15] ? 15'(16'(-s)) : s[14:0];
  endfunction

  // Register writes
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= '0;
      mode_r  <= tcs_pkg::MODE_LIN;
    end else if (cfg_wr) begin
      if (paddr[2] == tcs_pkg::REG_SHAPE) shape_r <= pwdata[15:0];
      else mode_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == tcs_pkg::REG_SHAPE) ? {16'b0, shape_r} : {30'b0, mode_r};
  assign pready = 1'b1;

  // Curve clamp and sign
  always_comb begin
    c_cl = shape_r;
    if (c_cl > tcs_pkg::CURVE_LIMIT) c_cl = tcs_pkg::CURVE_LIMIT;
    else if (c_cl < -tcs_pkg::CURVE_LIMIT) c_cl = -tcs_pkg::CURVE_LIMIT;
  end

  assign cfg.mode = mode_r;
  assign cfg.a    = c_cl[15] ? 15'(16'(-c_cl)) : c_cl[14:0];
  assign cfg.cpos = !c_cl[15] && (c_cl != 16'sd0);
  assign cfg.cneg = c_cl[15];
  assign cfg.b    = exp_b;
  assign cfg.bge  = exp_b >= tcs_pkg::ONE_Q30;

  // e^(-|c|) sequencer, restarted on each curve_shape write
  tcs_exp_unit u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr && (paddr[2] == tcs_pkg::REG_SHAPE)),
    .a     (exp_a(pwdata[15:0])),
    .busy  (exp_busy),
    .b     (exp_b)
  );

  // Handshake and pipe advance
  assign en            = cnt_r != 2'd2;
  assign in_chan.ready = en && !exp_busy;
  assign in_fire       = in_chan.valid && in_chan.ready;

  tcs_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_fire (in_fire),
    .in_cmd  (in_chan.command_in),
    .cfg     (cfg),
    .out_vld (pipe_vld),
    .out_cmd (pipe_cmd)
  );

  // Two-entry output skid buffer
  assign push = en && pipe_vld;
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= pipe_cmd;
  end

  assign out_chan.valid       = cnt_r != 2'd0;
  assign out_chan.command_out = fifo_r[rp_r];

endmodule

`default_nettype wire

// File: rtl/tcs_exp_unit.sv
// tcs_exp_unit: sequential e^(-a) in Q30 (Taylor series, reciprocal, four squarings).
// Depends on tcs_pkg.
`default_nettype none

module tcs_exp_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [14:0] a,
  output logic             busy,
  output logic [30:0]      b
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_SQR  = 5'b10000
  } exp_state_t;

  exp_state_t  state_r;
  logic [14:0] a_r;
  logic [31:0] term_r, sum_r, lo_r, quo_r, dvs_r;
  logic [32:0] rem_r;
  logic [3:0]  n_r;
  logic [4:0]  cnt_r;
  logic        rcp_r;
  logic [30:0] d_r, b_r;

  logic [28:0] y;
  logic [63:0] tprod, dprod;
  logic [32:0] rem2;
  logic        ge;
  logic [31:0] quo_nxt;
  logic [31:0] sum_nxt;

  // Datapath pieces
  assign y       = {a_r, 14'b0};
  assign tprod   = 64'(term_r) * 64'(y);
  assign dprod   = 64'(d_r) * 64'(d_r);
  assign rem2    = {rem_r[31:0], lo_r[31]};
  assign ge      = rem2 >= {1'b0, dvs_r};
  assign quo_nxt = {quo_r[30:0], ge};
  assign sum_nxt = sum_r + term_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rcp_r   <= 1'b0;
      n_r     <= '0;
    end else if (start) begin
      a_r     <= a;
      term_r  <= 32'(tcs_pkg::ONE_Q30);
      sum_r   <= 32'(tcs_pkg::ONE_Q30);
      n_r     <= 4'd1;
      state_r <= ST_MUL;
    end else begin
      case (state_r)
        ST_IDLE: begin
          state_r <= ST_IDLE;
        end
        ST_MUL: begin
          lo_r    <= tprod[61:30];
          rem_r   <= '0;
          dvs_r   <= {28'b0, n_r};
          cnt_r   <= '0;
          rcp_r   <= 1'b0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= ge ? (rem2 - {1'b0, dvs_r}) : rem2;
          lo_r  <= {lo_r[30:0], 1'b0};
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            cnt_r <= '0;
            if (rcp_r) begin
              d_r     <= quo_nxt[30:0];
              state_r <= ST_SQR;
            end else begin
              term_r  <= quo_nxt;
              state_r <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          sum_r <= sum_nxt;
          if (n_r == 4'd10) begin
            // 2^60 / sum: high word 2^28, low word zero
            rem_r   <= 33'h0_1000_0000;
            lo_r    <= '0;
            dvs_r   <= sum_nxt;
            rcp_r   <= 1'b1;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            n_r     <= n_r + 4'd1;
            state_r <= ST_MUL;
          end
        end
        ST_SQR: begin
          d_r   <= dprod[60:30];
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd3) begin
            b_r     <= dprod[60:30];
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = state_r != ST_IDLE;
  assign b    = b_r;

endmodule

`default_nettype wire

// File: rtl/tcs_pipe.sv
// tcs_pipe: fully pipelined curve datapath (powers, square-root chain, divider, rounding).
// Depends on tcs_pkg.
`default_nettype none

module tcs_pipe (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_fire,
  input  wire logic [15:0]         in_cmd,
  input  wire tcs_pkg::curve_cfg_t cfg,
  output logic                     out_vld,
  output logic [15:0]              out_cmd
);

  localparam int N_WHOLE   = 6;
  localparam int N_ROOT    = 14;
  localparam int SQ_BITS   = 31;
  localparam int ROOT_SPAN = SQ_BITS + 1;
  localparam int ROOT_BASE = 2 + N_WHOLE;
  localparam int DIV_BASE  = ROOT_BASE + N_ROOT * ROOT_SPAN;
  localparam int DIV_BITS  = 31;
  localparam int NS        = DIV_BASE + DIV_BITS;

  tcs_pkg::item_t st_r [NS];
  tcs_pkg::item_t nxt  [NS];
  logic [NS-1:0]  vld_r;
  logic           out_vld_r;
  logic [15:0]    out_cmd_r;

  // Clamp, sign and magnitude
  function automatic tcs_pkg::item_t f_entry(input logic [15:0] cmd,
                                             input tcs_pkg::curve_cfg_t c);
    tcs_pkg::item_t t;
    logic signed [15:0] v;
    t = '0;
    v = cmd;
    if (v < -16'sd16384) v = -16'sd16384;
    else if (v > 16'sd16384) v = 16'sd16384;
    t.neg  = v[15];
    t.x    = v[15] ? 15'(16'(-v)) : v[14:0];
    t.mode = c.mode;
    t.cpos = c.cpos;
    t.cneg = c.cneg;
    return t;
  endfunction

  // Base, exponent and polynomial operands
  function automatic tcs_pkg::item_t f_prep(input tcs_pkg::item_t s,
                                            input tcs_pkg::curve_cfg_t c);
    tcs_pkg::item_t t;
    logic [14:0] xc;
    logic [29:0] m;
    logic [16:0] e;
    t  = s;
    xc = tcs_pkg::ONE_Q14 - s.x;
    t.w    = s.cpos ? xc : s.x;
    m      = 30'(c.a) * 30'(s.cneg ? xc : s.x);
    t.dnum = s.cneg ? {s.x, 16'b0} : {xc, 16'b0};
    t.dden = 34'(tcs_pkg::ONE_Q30) + {m, 4'b0};
    t.acc  = tcs_pkg::ONE_Q30;
    if (s.mode == tcs_pkg::MODE_POWER) begin
      t.base = s.cneg ? {s.x, 16'b0} : {xc, 16'b0};
      e      = 17'((17'd4096 + 17'(c.a)) << 2);
    end else begin
      t.base = c.b;
      e      = 17'(tcs_pkg::ONE_Q14) - 17'(t.w);
    end
    t.whole = e[16:14];
    t.nfrac = e[13:0];
    return t;
  endfunction

  // Integer part of the exponent: one multiply per stage
  function automatic tcs_pkg::item_t f_whole(input tcs_pkg::item_t s, input int k);
    tcs_pkg::item_t t;
    logic [61:0] p;
    t = s;
    p = 62'(s.acc) * 62'(s.base);
    if (s.whole > 3'(k)) t.acc = p[60:30];
    return t;
  endfunction

  // One result bit of floor(sqrt(base * 2^30))
  function automatic tcs_pkg::item_t f_sqrt(input tcs_pkg::item_t s, input int bit_pos,
                                            input logic first);
    tcs_pkg::item_t t;
    logic [60:0] rem;
    logic [30:0] res;
    logic [62:0] trial;
    t = s;
    if (first) begin
      rem = {s.base, 30'b0};
      res = '0;
    end else begin
      rem = s.srem;
      res = s.sres;
    end
    trial = (63'(res) << (bit_pos + 1)) + (63'd1 << (2 * bit_pos));
    if ({2'b0, rem} >= trial) begin
      rem = 61'({2'b0, rem} - trial);
      res = res | (31'd1 << bit_pos);
    end
    t.srem = rem;
    t.sres = res;
    return t;
  endfunction

  // Take the new root as base, multiply it in when its exponent bit is set
  function automatic tcs_pkg::item_t f_rmul(input tcs_pkg::item_t s, input int fbit);
    tcs_pkg::item_t t;
    logic [61:0] p;
    t      = s;
    t.base = s.sres;
    p      = 62'(s.acc) * 62'(s.sres);
    if (s.nfrac[4'(fbit)]) t.acc = p[60:30];
    return t;
  endfunction

  // One quotient bit of (num * 2^30) / den
  function automatic tcs_pkg::item_t f_div(input tcs_pkg::item_t s, input int bit_pos,
                                           input logic first,
                                           input tcs_pkg::curve_cfg_t c);
    tcs_pkg::item_t t;
    logic [60:0] rem;
    logic [30:0] q;
    logic [30:0] num;
    logic [65:0] dsh;
    t = s;
    if (first) begin
      if (s.mode == tcs_pkg::MODE_EXPO) begin
        num    = (s.acc > c.b) ? (s.acc - c.b) : '0;
        t.dden = 34'(tcs_pkg::ONE_Q30 - c.b);
      end else begin
        num = s.dnum;
      end
      rem = {num, 30'b0};
      q   = '0;
    end else begin
      rem = s.drem;
      q   = s.quot;
    end
    dsh = 66'(t.dden) << bit_pos;
    if ({5'b0, rem} >= dsh) begin
      rem = 61'({5'b0, rem} - dsh);
      q   = q | (31'd1 << bit_pos);
    end
    t.drem = rem;
    t.quot = q;
    return t;
  endfunction

  // Pick the curve result, round to Q14, saturate and restore the sign
  function automatic logic [15:0] f_final(input tcs_pkg::item_t s,
                                          input tcs_pkg::curve_cfg_t c);
    logic [30:0] r;
    logic [30:0] q;
    logic [31:0] sum;
    logic [15:0] rr;
    case (s.mode)
      tcs_pkg::MODE_POWER: begin
        r = s.cneg ? s.acc : (tcs_pkg::ONE_Q30 - s.acc);
      end
      tcs_pkg::MODE_EXPO: begin
        if (!s.cpos && !s.cneg) begin
          r = {s.x, 16'b0};
        end else begin
          if (c.bge) q = {s.w, 16'b0};
          else q = (s.quot > tcs_pkg::ONE_Q30) ? tcs_pkg::ONE_Q30 : s.quot;
          r = s.cpos ? (tcs_pkg::ONE_Q30 - q) : q;
        end
      end
      tcs_pkg::MODE_POLY: begin
        r = s.cneg ? s.quot : (tcs_pkg::ONE_Q30 - s.quot);
      end
      default: begin
        r = {s.x, 16'b0};
      end
    endcase
    sum = {1'b0, r} + 32'd32768;
    rr  = sum[31:16];
    if (rr > 16'd16384) rr = 16'd16384;
    return s.neg ? 16'(-rr) : rr;
  endfunction

  // Stage logic
  assign nxt[0] = f_entry(in_cmd, cfg);
  assign nxt[1] = f_prep(st_r[0], cfg);

  for (genvar gk = 0; gk < N_WHOLE; gk++) begin : g_whole
    assign nxt[2 + gk] = f_whole(st_r[1 + gk], gk);
  end

  for (genvar gj = 0; gj < N_ROOT; gj++) begin : g_root
    for (genvar gi = 0; gi < SQ_BITS; gi++) begin : g_bit
      assign nxt[ROOT_BASE + gj * ROOT_SPAN + gi] =
        f_sqrt(st_r[ROOT_BASE + gj * ROOT_SPAN + gi - 1], SQ_BITS - 1 - gi, gi == 0);
    end
    assign nxt[ROOT_BASE + gj * ROOT_SPAN + SQ_BITS] =
      f_rmul(st_r[ROOT_BASE + gj * ROOT_SPAN + SQ_BITS - 1], N_ROOT - 1 - gj);
  end

  for (genvar gd = 0; gd < DIV_BITS; gd++) begin : g_div
    assign nxt[DIV_BASE + gd] = f_div(st_r[DIV_BASE + gd - 1], DIV_BITS - 1 - gd,
                                      gd == 0, cfg);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NS-2:0], in_fire};
      out_vld_r <= vld_r[NS-1];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      st_r      <= nxt;
      out_cmd_r <= f_final(st_r[NS-1], cfg);
    end
  end

  assign out_vld = out_vld_r;
  assign out_cmd = out_cmd_r;

endmodule

`default_nettype wire

// File: rtl/tcs_checker.sv
// tcs_sva: port-level assertions for the throttle curve shaper, bound to the top.
// Depends on throttle_curve_shaper and tcs_if.
`default_nettype none

module tcs_sva (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_cmd,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr
);

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd))
    else $error("result changed or dropped while stalled");

  // Shaped command stays within +-1.0
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_cmd) <= 16'sd16384 && $signed(out_cmd) >= -16'sd16384))
    else $error("result outside +-1.0");

  // New curve steepness blocks input while e^(-a) is recomputed
  a_shape_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=> !in_ready)
    else $error("input taken right after curve_shape write");

endmodule

bind throttle_curve_shaper tcs_sva u_tcs_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_cmd   (out_chan.command_out),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr)
);

`default_nettype wire

// File: tb/tcs_checker.sv
// tcs_checker: watches the command channels and the APB port, predicts each shaped command.
// Depends on tcs_pkg and tcs_if; instantiated beside the DUT by the testbench top.
`timescale 1ns / 1ps

module tcs_checker (
  input  logic        clk,
  input  logic        rst_n,
  tcs_in_if           in_mon,
  tcs_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  localparam longint unsigned Q30 = 64'd1 << 30;

  logic signed [15:0] shape_reg;
  logic [1:0]         mode_reg;
  logic signed [15:0] shaped_q[$];

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // base^(num / 2^bits): whole part by multiplies, fraction by repeated roots
  function automatic longint unsigned frac_power(longint unsigned base, longint unsigned num,
                                                 int bits);
    longint unsigned acc, whole, r;
    acc = Q30;
    whole = num >> bits;
    r = base;
    while (whole != 0) begin
      acc = q30_mul(acc, base);
      whole--;
    end
    for (int j = bits; j > 0; j--) begin
      r = sqrt_floor(r << 30);
      if ((num >> (j - 1)) & 1) acc = q30_mul(acc, r);
    end
    return acc;
  endfunction

  // e^(-a), a in Q4.12: series for e^(a/16), invert, square four times
  function automatic longint unsigned exp_decay(longint unsigned a);
    longint unsigned y, term, sum, d;
    y = a << 14;
    term = Q30;
    sum = Q30;
    for (int n = 1; n <= 10; n++) begin
      term = q30_mul(term, y) / n;
      sum = sum + term;
    end
    d = (64'd1 << 60) / sum;
    for (int n = 0; n < 4; n++) d = q30_mul(d, d);
    return d;
  endfunction

  function automatic logic signed [15:0] shape_command(logic signed [15:0] cmd,
                                                       logic signed [15:0] shape,
                                                       logic [1:0] mode);
    longint signed val, c;
    longint unsigned a, x, w, r, q, b, p, num, den;
    bit neg;
    logic [15:0] res;
    val = cmd;
    if (val < -16384) val = -16384;
    if (val > 16384) val = 16384;
    neg = val < 0;
    x = neg ? -val : val;
    c = shape;
    if (c > 20480) c = 20480;
    if (c < -20480) c = -20480;
    a = (c < 0) ? -c : c;
    case (mode)
      tcs_pkg::MODE_POWER: begin
        if (c >= 0) r = Q30 - frac_power((16384 - x) << 16, 4096 + a, 12);
        else r = frac_power(x << 16, 4096 + a, 12);
      end
      tcs_pkg::MODE_EXPO: begin
        if (c == 0) begin
          r = x << 16;
        end else begin
          b = exp_decay(a);
          w = (c > 0) ? (16384 - x) : x;
          p = frac_power(b, 16384 - w, 14);
          if (b >= Q30) begin
            q = w << 16;
          end else begin
            num = (p > b) ? (p - b) : 0;
            q = (num << 30) / (Q30 - b);
            if (q > Q30) q = Q30;
          end
          r = (c > 0) ? (Q30 - q) : q;
        end
      end
      tcs_pkg::MODE_POLY: begin
        if (c >= 0) begin
          num = (16384 - x) << 16;
          den = Q30 + ((a * x) << 4);
          r = Q30 - (num << 30) / den;
        end else begin
          num = x << 16;
          den = Q30 + ((a * (16384 - x)) << 4);
          r = (num << 30) / den;
        end
      end
      default: r = x << 16;
    endcase
    r = (r + (64'd1 << 15)) >> 16;
    if (r > 16384) r = 16384;
    res = neg ? (16'd0 - r[15:0]) : r[15:0];
    return res;
  endfunction

  assign pending = shaped_q.size();

  always @(posedge clk) begin
    logic signed [15:0] exp_val;
    if (!rst_n) begin
      shape_reg <= '0;
      mode_reg <= tcs_pkg::MODE_LIN;
      fail_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite) begin
        if (paddr[2] == tcs_pkg::REG_SHAPE) shape_reg <= pwdata[15:0];
        else mode_reg <= pwdata[1:0];
      end
      // command transfer in
      if (in_mon.valid && in_mon.ready)
        shaped_q.push_back(shape_command(in_mon.command_in, shape_reg, mode_reg));
      // shaped command transfer out
      if (out_mon.valid && out_mon.ready) begin
        if (shaped_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: unexpected output %0d", out_mon.command_out);
        end else begin
          exp_val = shaped_q.pop_front();
          if (exp_val !== out_mon.command_out) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: command_out expected %0d got %0d (shape %0d mode %0d)",
                       exp_val, out_mon.command_out, shape_reg, mode_reg);
          end
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// testbench: drives commands and curve settings into throttle_curve_shaper, gives the verdict.
// Depends on tcs_pkg, tcs_if, the DUT and tcs_checker.
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] ADDR_SHAPE = 3'd0;
  localparam logic [2:0] ADDR_MODE  = 3'd4;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_PHASE = 9;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_req = 0;
  bit          burst = 0;
  int          stall_left = 0;

  tcs_in_if  in_bus();
  tcs_out_if out_bus();

  initial begin
    in_bus.valid = 0;
    in_bus.command_in = '0;
    out_bus.ready = 0;
  end

  always #5 clk = ~clk;

  throttle_curve_shaper i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_bus), .out_chan(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tcs_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_bus), .out_mon(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, bursts, and one long hold on request
  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      stall_left <= 1500;
      out_bus.ready <= 0;
    end else if (burst || pick < 70) begin
      out_bus.ready <= 1;
    end else begin
      stall_left <= (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      out_bus.ready <= 0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (burst || pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_command(logic signed [15:0] cmd);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_bus.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.command_in <= cmd;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // drain: stop offering, wait until every pending result has come out
  task automatic drain();
    in_bus.valid <= 0;
    @(posedge clk);
    // read the outstanding count away from the edge
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_command();
    logic signed [15:0] edges[10] = '{-16'sd32768, 16'sd32767, 16'sd16384, -16'sd16384, 16'sd0,
                                      16'sd1, -16'sd1, 16'sd16385, -16'sd16385, 16'sd16383};
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return edges[$urandom_range(0, 9)];
    if (pick < 30) return 16'($urandom());
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    logic signed [15:0] directed[20] = '{-16'sd32768, 16'sd32767, 16'sd16384, -16'sd16384,
        16'sd0, 16'sd1, -16'sd1, 16'sd16385, -16'sd16385, 16'sd8192, -16'sd8192,
        16'sd16383, -16'sd16383, 16'sd4096, -16'sd12000, 16'sh5555, -16'sh2AAB,
        16'sd100, -16'sd30000, 16'sd20000};
    logic signed [15:0] shapes[7];
    int phase;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed commands at reset settings (linear), then power at full steepness
    foreach (directed[i]) send_command(directed[i]);
    drain();
    write_reg(ADDR_SHAPE, 32'd20480);
    write_reg(ADDR_MODE, 32'(tcs_pkg::MODE_POWER));
    foreach (directed[i]) send_command(directed[i]);
    drain();

    // sweep every mode against extreme, out-of-range and random steepness
    phase = 0;
    for (int m = 0; m < 4; m++) begin
      shapes = '{16'sd0, 16'sd20480, -16'sd20480, 16'sd32767, -16'sd32768,
                 16'($signed($urandom_range(0, 40960)) - 20480), 16'($urandom())};
      foreach (shapes[s]) begin
        write_reg(ADDR_SHAPE, {16'($urandom_range(0, 65535)), shapes[s][15:0]});
        write_reg(ADDR_MODE, {30'($urandom()), 2'(m)});
        // the hold phase sends back to back, enough to fill the whole pipe
        burst = (phase % 5 == 3) || (phase == HOLD_PHASE);
        if (phase == HOLD_PHASE) hold_req = 1;
        repeat ((phase == HOLD_PHASE) ? 600 : 20) send_command(random_command());
        phase++;
        drain();
      end
    end
    burst = 0;

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
